/* design/nfa_pkg.sv */
// Shared types and constants of the next-fit block allocator.
package nfa_pkg;

	localparam int NFA_MAX_BLOCKS = 64;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_ALLOC = 2'd1,
		MODE_DUMP  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		STAT_GRANTED   = 3'd0,
		STAT_NO_FIT    = 3'd1,
		STAT_LOADED    = 3'd2,
		STAT_REJECTED  = 3'd3,
		STAT_DUMP_ITEM = 3'd4,
		STAT_DUMP_NONE = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_LINK,
		ST_A_HEAD,
		ST_A_WALK,
		ST_D_HEAD,
		ST_D_WALK,
		ST_D_FLUSH
	} state_t;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [31:0] addr;
		logic [31:0] size;
		logic        last;
	} res_t;

endpackage

/* design/nfa_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module nfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/nfa_ctrl.sv */
// Sequencer that loads, walks and updates the circular free list held in the RAMs.
module nfa_ctrl import nfa_pkg::*; #(
	parameter int MAX_BLOCKS = NFA_MAX_BLOCKS,
	localparam int IW = $clog2(MAX_BLOCKS),
	localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    mode,
	input  logic [31:0]   block_address,
	input  logic [31:0]   amount,
	output res_t          res,
	output logic          data_we,
	output logic [IW-1:0] data_waddr,
	output logic [63:0]   data_wdata,
	output logic [IW-1:0] data_raddr,
	input  logic [63:0]   data_rdata,
	output logic          link_we,
	output logic [IW-1:0] link_waddr,
	output logic [IW-1:0] link_wdata,
	output logic [IW-1:0] link_raddr,
	input  logic [IW-1:0] link_rdata
);

	state_t        state_q, state_d;
	logic [CW-1:0] loaded_q, loaded_d;
	logic [CW-1:0] live_q, live_d;
	logic          open_q, open_d;
	logic [IW-1:0] rover_q, rover_d;
	logic [IW-1:0] cur_q, cur_d;
	logic [IW-1:0] prev_q, prev_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [31:0]   amt_q, amt_d;
	logic          pend_q, pend_d;
	logic [31:0]   pend_addr_q, pend_addr_d;
	logic [31:0]   pend_size_q, pend_size_d;

	logic [31:0]   rd_addr;
	logic [31:0]   rd_size;
	logic [31:0]   rem;
	logic          fits;
	logic          walk_end;
	logic [IW-1:0] new_idx;

	assign rd_addr  = data_rdata[63:32];
	assign rd_size  = data_rdata[31:0];
	assign fits     = (rd_size >= amt_q);
	assign rem      = rd_size - amt_q;
	assign walk_end = (cnt_q == (live_q - CW'(1)));
	assign new_idx  = loaded_q[IW-1:0];
	assign busy     = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			live_q   <= '0;
			open_q   <= 1'b1;
			rover_q  <= '0;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
		end else begin
			loaded_q <= loaded_d;
			live_q   <= live_d;
			open_q   <= open_d;
			rover_q  <= rover_d;
			cnt_q    <= cnt_d;
			pend_q   <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q       <= cur_d;
		prev_q      <= prev_d;
		amt_q       <= amt_d;
		pend_addr_q <= pend_addr_d;
		pend_size_q <= pend_size_d;
	end

	always_comb begin
		state_d     = state_q;
		loaded_d    = loaded_q;
		live_d      = live_q;
		open_d      = open_q;
		rover_d     = rover_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		cnt_d       = cnt_q;
		amt_d       = amt_q;
		pend_d      = pend_q;
		pend_addr_d = pend_addr_q;
		pend_size_d = pend_size_q;
		res         = '0;
		data_we     = 1'b0;
		data_waddr  = cur_q;
		data_wdata  = {rd_addr, rem};
		data_raddr  = link_rdata;
		link_we     = 1'b0;
		link_waddr  = prev_q;
		link_wdata  = link_rdata;
		link_raddr  = link_rdata;
		case (state_q)
			ST_IDLE: begin
				link_raddr = rover_q;
				data_raddr = rover_q;
				if (start) begin
					case (mode)
						MODE_LOAD: begin
							if (!open_q || (loaded_q >= CW'(MAX_BLOCKS))) begin
								res.valid  = 1'b1;
								res.status = STAT_REJECTED;
								res.last   = 1'b1;
							end else begin
								data_we    = 1'b1;
								data_waddr = new_idx;
								data_wdata = {block_address, amount};
								link_we    = 1'b1;
								link_waddr = new_idx;
								link_wdata = '0;
								cur_d      = new_idx;
								rover_d    = new_idx;
								loaded_d   = loaded_q + CW'(1);
								live_d     = live_q + CW'(1);
								state_d    = ST_LOAD_LINK;
							end
						end
						MODE_ALLOC: begin
							open_d = 1'b0;
							amt_d  = amount;
							if (live_q == '0) begin
								res.valid  = 1'b1;
								res.status = STAT_NO_FIT;
								res.last   = 1'b1;
							end else begin
								prev_d  = rover_q;
								cnt_d   = '0;
								state_d = ST_A_HEAD;
							end
						end
						MODE_DUMP: begin
							pend_d = 1'b0;
							cnt_d  = '0;
							if (live_q == '0) begin
								state_d = ST_D_FLUSH;
							end else begin
								state_d = ST_D_HEAD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_LOAD_LINK: begin
				if (cur_q != '0) begin
					link_we    = 1'b1;
					link_waddr = cur_q - IW'(1);
					link_wdata = cur_q;
				end
				res.valid  = 1'b1;
				res.status = STAT_LOADED;
				res.last   = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_A_HEAD: begin
				cur_d   = link_rdata;
				state_d = ST_A_WALK;
			end
			ST_A_WALK: begin
				if (fits) begin
					res.valid  = 1'b1;
					res.status = STAT_GRANTED;
					res.addr   = rd_addr;
					res.size   = rem;
					res.last   = 1'b1;
					if (rem != '0) begin
						data_we = 1'b1;
						rover_d = prev_q;
					end else if (live_q == CW'(1)) begin
						data_we    = 1'b1;
						data_wdata = {rd_addr, 32'd0};
						live_d     = '0;
					end else begin
						link_we = 1'b1;
						rover_d = prev_q;
						live_d  = live_q - CW'(1);
					end
					state_d = ST_IDLE;
				end else if (walk_end) begin
					res.valid  = 1'b1;
					res.status = STAT_NO_FIT;
					res.last   = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					prev_d = cur_q;
					cur_d  = link_rdata;
					cnt_d  = cnt_q + CW'(1);
				end
			end
			ST_D_HEAD: begin
				cur_d   = link_rdata;
				state_d = ST_D_WALK;
			end
			ST_D_WALK: begin
				if (rd_size != '0) begin
					if (pend_q) begin
						res.valid  = 1'b1;
						res.status = STAT_DUMP_ITEM;
						res.addr   = pend_addr_q;
						res.size   = pend_size_q;
					end
					pend_d      = 1'b1;
					pend_addr_d = rd_addr;
					pend_size_d = rd_size;
				end
				if (walk_end) begin
					state_d = ST_D_FLUSH;
				end else begin
					cur_d = link_rdata;
					cnt_d = cnt_q + CW'(1);
				end
			end
			ST_D_FLUSH: begin
				res.valid = 1'b1;
				res.last  = 1'b1;
				if (pend_q) begin
					res.status = STAT_DUMP_ITEM;
					res.addr   = pend_addr_q;
					res.size   = pend_size_q;
				end else begin
					res.status = STAT_DUMP_NONE;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_live_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= loaded_q)
		else $error("More live blocks than loaded slots.");

	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CW'(MAX_BLOCKS))
		else $error("Loaded count exceeds capacity.");

	a_closed_stays: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |=> !open_q)
		else $error("Loading reopened after an allocate.");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_A_WALK || state_q == ST_D_WALK) |-> (cnt_q < live_q))
		else $error("List walk ran past the live blocks.");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_A_WALK) |-> !(data_we && link_we))
		else $error("Allocate updated both size and link.");
`endif

endmodule

/* design/next_fit_block_allocator.sv */
// Top level of the next-fit block allocator: RAMs, sequencer and result register.
// A word is taken when start is high while busy is low; each result word shows on the
// result ports for one cycle with done high, the cycle after the sequencer produces it,
// and it cannot be held off. An accepted load passes through ST_LOAD_LINK; a rejected
// load and an allocate that meets an empty list are answered from idle, and a dump of an
// empty list goes straight to ST_D_FLUSH. Otherwise an allocate passes through ST_A_HEAD
// and ST_A_WALK, and a dump through ST_D_HEAD, ST_D_WALK and ST_D_FLUSH; a walk follows
// the link RAM one read per cycle. A dump delivers its nonzero-size entries, the one
// after the rover first and the rover last, at most one per cycle, and marks the final
// one with last. Loads are taken only until the first allocate.
module next_fit_block_allocator import nfa_pkg::*; #(
	parameter int MAX_BLOCKS = NFA_MAX_BLOCKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] block_address,
	input  logic [31:0] amount,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] result_address,
	output logic [31:0] result_size,
	output logic        last
);

	localparam int IW = $clog2(MAX_BLOCKS);

	res_t          res;
	logic          done_q;
	status_t       status_q;
	logic [31:0]   addr_q;
	logic [31:0]   size_q;
	logic          last_q;
	logic          data_we;
	logic [IW-1:0] data_waddr;
	logic [63:0]   data_wdata;
	logic [IW-1:0] data_raddr;
	logic [63:0]   data_rdata;
	logic          link_we;
	logic [IW-1:0] link_waddr;
	logic [IW-1:0] link_wdata;
	logic [IW-1:0] link_raddr;
	logic [IW-1:0] link_rdata;

	nfa_ctrl #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.block_address(block_address),
		.amount       (amount),
		.res          (res),
		.data_we      (data_we),
		.data_waddr   (data_waddr),
		.data_wdata   (data_wdata),
		.data_raddr   (data_raddr),
		.data_rdata   (data_rdata),
		.link_we      (link_we),
		.link_waddr   (link_waddr),
		.link_wdata   (link_wdata),
		.link_raddr   (link_raddr),
		.link_rdata   (link_rdata)
	);

	nfa_ram #(
		.WIDTH(64),
		.DEPTH(MAX_BLOCKS)
	) u_data_ram (
		.clk  (clk),
		.we   (data_we),
		.waddr(data_waddr),
		.wdata(data_wdata),
		.raddr(data_raddr),
		.rdata(data_rdata)
	);

	nfa_ram #(
		.WIDTH(IW),
		.DEPTH(MAX_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= res.status;
		addr_q   <= res.addr;
		size_q   <= res.size;
		last_q   <= res.last;
	end

	assign done           = done_q;
	assign status         = status_q;
	assign result_address = addr_q;
	assign result_size    = size_q;
	assign last           = last_q;

endmodule
